// ===== rtl/core/idea_pkg.sv =====
package idea_pkg;

    // Sixteen-bit words per subkey row: four for the key layer, two for the MA structure
    localparam int ROW_KEYS = 6;
    // Row counter width, wide enough for the largest round count plus the output row
    localparam int ROW_W = 4;
    // Key register width and rotation between groups of eight subkeys
    localparam int KEY_W = 128;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_DECRYPT  = 2'd2;

    // Subkey slot codes inside one row
    localparam logic [2:0] SLOT_MUL1 = 3'd0;
    localparam logic [2:0] SLOT_ADD2 = 3'd1;
    localparam logic [2:0] SLOT_ADD3 = 3'd2;
    localparam logic [2:0] SLOT_MUL4 = 3'd3;
    localparam logic [2:0] SLOT_MA5  = 3'd4;
    localparam logic [2:0] SLOT_MA6  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_DEC,
        ST_INV,
        ST_INV_WR,
        ST_ROUND,
        ST_XFORM
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ENC_WR,
        DP_DEC_WR,
        DP_INV_LOAD,
        DP_INV_STEP,
        DP_INV_WR,
        DP_PH0,
        DP_PH1,
        DP_PH2,
        DP_XFORM
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [ROW_W-1:0] row;
        logic [2:0]       slot;
        logic             last_word;
    } t_dp_cmd;

    typedef struct packed {
        logic need_inv;
    } t_dp_status;

    // Multiplication modulo 2^16+1, the word zero standing for 2^16.
    function automatic logic [15:0] mmul(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        logic [15:0] lo;
        logic [15:0] hi;
        p  = 32'(a) * 32'(b);
        lo = p[15:0];
        hi = p[31:16];
        if (p != 32'd0) begin
            mmul = lo - hi + 16'(lo < hi);
        end else if (a == 16'd0) begin
            mmul = 16'd1 - b;
        end else begin
            mmul = 16'd1 - a;
        end
    endfunction

endpackage

// ===== rtl/core/idea_ifs.sv =====
interface idea_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_block;

    modport source (output valid, output data_block, input ready);
    modport sink   (input valid, input data_block, output ready);
endinterface

interface idea_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_block;

    modport source (output valid, output result_block, input ready);
    modport sink   (input valid, input result_block, output ready);
endinterface

// ===== rtl/core/idea_datapath.sv =====
module idea_datapath #(
    parameter int ROUNDS = 8
) (
    input  logic                  i_clk,
    input  idea_pkg::t_dp_cmd     i_cmd,
    input  logic [63:0]           i_data_block,
    input  logic [63:0]           i_key_high,
    input  logic [63:0]           i_key_low,
    input  logic                  i_decrypt,
    output idea_pkg::t_dp_status  o_status,
    output logic [63:0]           o_result_block
);

    localparam int NROWS = ROUNDS + 1;
    localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROUNDS);

    // Subkey stores, one row of six words per round plus the output row
    logic [16*idea_pkg::ROW_KEYS-1:0] r_enc [NROWS];
    logic [16*idea_pkg::ROW_KEYS-1:0] r_dec [NROWS];

    logic [idea_pkg::KEY_W-1:0] r_kreg;
    logic [15:0] r_x1, r_x2, r_x3, r_x4, r_t2;
    logic [15:0] r_inv_r, r_inv_b;
    logic [63:0] r_out;

    logic [RW-1:0] w_row;
    logic [RW-1:0] w_src_row;
    logic [RW-1:0] w_rd_row;
    logic          w_keygen;
    logic          w_edge_row;
    logic [2:0]    w_src_slot;
    logic [16*idea_pkg::ROW_KEYS-1:0] w_enc_row;
    logic [15:0]   w_k [idea_pkg::ROW_KEYS];
    logic [15:0]   w_src_val;
    logic          w_is_inv;
    logic          w_is_neg;
    logic [15:0]   w_direct;
    logic [15:0]   w_ma_a, w_mb_a, w_ma_b, w_mb_b;
    logic [15:0]   w_ma, w_mb;
    logic [15:0]   w_t2b;

    assign w_row    = i_cmd.row[RW-1:0];
    assign w_keygen = (i_cmd.op == idea_pkg::DP_DEC_WR) || (i_cmd.op == idea_pkg::DP_INV_LOAD);

    // Decryption row r draws its key layer from encryption row R-r and its
    // MA words from row R-r-1; the two adds swap except on the end rows.
    assign w_edge_row = (w_row == '0) || (w_row == LAST_ROW);
    assign w_src_row  = (i_cmd.slot < idea_pkg::SLOT_MA5) ? (LAST_ROW - w_row)
                                                          : (LAST_ROW - w_row - RW'(1));
    assign w_rd_row   = w_keygen ? w_src_row : w_row;
    assign w_enc_row  = r_enc[w_rd_row];

    always_comb begin
        case (i_cmd.slot)
            idea_pkg::SLOT_ADD2: w_src_slot = w_edge_row ? idea_pkg::SLOT_ADD2 : idea_pkg::SLOT_ADD3;
            idea_pkg::SLOT_ADD3: w_src_slot = w_edge_row ? idea_pkg::SLOT_ADD3 : idea_pkg::SLOT_ADD2;
            default:             w_src_slot = i_cmd.slot;
        endcase
    end

    assign w_src_val = w_enc_row[16*w_src_slot +: 16];
    assign w_is_inv  = (i_cmd.slot == idea_pkg::SLOT_MUL1) || (i_cmd.slot == idea_pkg::SLOT_MUL4);
    assign w_is_neg  = (i_cmd.slot == idea_pkg::SLOT_ADD2) || (i_cmd.slot == idea_pkg::SLOT_ADD3);
    assign w_direct  = w_is_neg ? (16'd0 - w_src_val) : w_src_val;

    assign o_status.need_inv = w_is_inv && (w_src_val > 16'd1);

    // Round keys from the selected set
    always_comb begin
        for (int i = 0; i < idea_pkg::ROW_KEYS; i++) begin
            w_k[i] = i_decrypt ? r_dec[w_row][16*i +: 16] : w_enc_row[16*i +: 16];
        end
    end

    // Operand selection for the two shared multipliers
    always_comb begin
        w_ma_a = r_x1;
        w_ma_b = w_k[idea_pkg::SLOT_MUL1];
        w_mb_a = r_x4;
        w_mb_b = w_k[idea_pkg::SLOT_MUL4];
        case (i_cmd.op)
            idea_pkg::DP_PH1: begin
                w_ma_a = r_x1 ^ r_x3;
                w_ma_b = w_k[idea_pkg::SLOT_MA5];
            end
            idea_pkg::DP_PH2: begin
                w_ma_a = (r_x2 ^ r_x4) + r_t2;
                w_ma_b = w_k[idea_pkg::SLOT_MA6];
            end
            idea_pkg::DP_INV_STEP: begin
                w_ma_a = r_inv_r;
                w_ma_b = r_inv_b;
                w_mb_a = r_inv_b;
                w_mb_b = r_inv_b;
            end
            default: begin
            end
        endcase
    end

    assign w_ma  = idea_pkg::mmul(w_ma_a, w_ma_b);
    assign w_mb  = idea_pkg::mmul(w_mb_a, w_mb_b);
    assign w_t2b = w_ma + r_t2;

    // Data registers and subkey writes
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            idea_pkg::DP_LOAD: begin
                r_x1   <= i_data_block[63:48];
                r_x2   <= i_data_block[47:32];
                r_x3   <= i_data_block[31:16];
                r_x4   <= i_data_block[15:0];
                r_kreg <= {i_key_high, i_key_low};
            end
            idea_pkg::DP_ENC_WR: begin
                r_enc[w_row][16*i_cmd.slot +: 16] <= r_kreg[127:112];
                if (i_cmd.last_word) begin
                    r_kreg <= {r_kreg[86:0], r_kreg[127:87]};
                end else begin
                    r_kreg <= {r_kreg[111:0], r_kreg[127:112]};
                end
            end
            idea_pkg::DP_DEC_WR: begin
                r_dec[w_row][16*i_cmd.slot +: 16] <= w_direct;
            end
            idea_pkg::DP_INV_LOAD: begin
                r_inv_r <= 16'd1;
                r_inv_b <= w_src_val;
            end
            idea_pkg::DP_INV_STEP: begin
                r_inv_r <= w_ma;
                r_inv_b <= w_mb;
            end
            idea_pkg::DP_INV_WR: begin
                r_dec[w_row][16*i_cmd.slot +: 16] <= r_inv_r;
            end
            idea_pkg::DP_PH0: begin
                r_x1 <= w_ma;
                r_x2 <= r_x2 + w_k[idea_pkg::SLOT_ADD2];
                r_x3 <= r_x3 + w_k[idea_pkg::SLOT_ADD3];
                r_x4 <= w_mb;
            end
            idea_pkg::DP_PH1: begin
                r_t2 <= w_ma;
            end
            idea_pkg::DP_PH2: begin
                r_x1 <= r_x1 ^ w_ma;
                r_x4 <= r_x4 ^ w_t2b;
                r_x2 <= r_x3 ^ w_ma;
                r_x3 <= w_t2b ^ r_x2;
            end
            idea_pkg::DP_XFORM: begin
                r_out <= {w_ma, r_x3 + w_k[idea_pkg::SLOT_ADD2],
                          r_x2 + w_k[idea_pkg::SLOT_ADD3], w_mb};
            end
            default: begin
            end
        endcase
    end

    assign o_result_block = r_out;

endmodule

// ===== rtl/core/idea_ctrl.sv =====
module idea_ctrl #(
    parameter int ROUNDS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_key_wr,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  idea_pkg::t_dp_status  i_status,
    output idea_pkg::t_dp_cmd     o_cmd
);

    localparam logic [idea_pkg::ROW_W-1:0] LAST_ROW  = idea_pkg::ROW_W'(ROUNDS);
    localparam logic [idea_pkg::ROW_W-1:0] LAST_RND  = idea_pkg::ROW_W'(ROUNDS - 1);

    idea_pkg::t_state r_state, n_state;
    logic [idea_pkg::ROW_W-1:0] r_row, n_row;
    logic [2:0] r_slot, n_slot;
    logic [2:0] r_word, n_word;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_iter, n_iter;
    logic       r_keys_ready, n_keys_ready;
    logic       r_out_valid, n_out_valid;

    logic w_last_key;
    logic w_row_end;
    logic w_out_free;

    // The output row holds only the four key-layer words
    assign w_last_key = (r_row == LAST_ROW) && (r_slot == idea_pkg::SLOT_MUL4);
    assign w_row_end  = (r_slot == idea_pkg::SLOT_MA6);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            idea_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_keys_ready ? idea_pkg::ST_ROUND : idea_pkg::ST_ENC;
                end
            end
            idea_pkg::ST_ENC: begin
                if (w_last_key) begin
                    n_state = idea_pkg::ST_DEC;
                end
            end
            idea_pkg::ST_DEC: begin
                if (i_status.need_inv) begin
                    n_state = idea_pkg::ST_INV;
                end else if (w_last_key) begin
                    n_state = idea_pkg::ST_ROUND;
                end
            end
            idea_pkg::ST_INV: begin
                if (r_iter == 4'd15) begin
                    n_state = idea_pkg::ST_INV_WR;
                end
            end
            idea_pkg::ST_INV_WR: begin
                n_state = w_last_key ? idea_pkg::ST_ROUND : idea_pkg::ST_DEC;
            end
            idea_pkg::ST_ROUND: begin
                if ((r_phase == 2'd2) && (r_row == LAST_RND)) begin
                    n_state = idea_pkg::ST_XFORM;
                end
            end
            idea_pkg::ST_XFORM: begin
                if (w_out_free) begin
                    n_state = idea_pkg::ST_IDLE;
                end
            end
            default: n_state = idea_pkg::ST_IDLE;
        endcase
    end

    // Commands and counter updates
    always_comb begin
        o_cmd.op        = idea_pkg::DP_NOP;
        o_cmd.row       = r_row;
        o_cmd.slot      = r_slot;
        o_cmd.last_word = (r_word == 3'd7);
        o_in_ready      = 1'b0;
        n_row           = r_row;
        n_slot          = r_slot;
        n_word          = r_word;
        n_phase         = r_phase;
        n_iter          = r_iter;
        n_keys_ready    = r_keys_ready && !i_key_wr;
        n_out_valid     = r_out_valid && !i_out_ready;
        case (r_state)
            idea_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = idea_pkg::DP_LOAD;
                    n_row    = '0;
                    n_slot   = '0;
                    n_word   = '0;
                    n_phase  = '0;
                end
            end
            idea_pkg::ST_ENC: begin
                o_cmd.op = idea_pkg::DP_ENC_WR;
                n_word   = r_word + 3'd1;
                if (w_last_key) begin
                    n_row  = '0;
                    n_slot = '0;
                end else if (w_row_end) begin
                    n_row  = r_row + 1'b1;
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + 3'd1;
                end
            end
            idea_pkg::ST_DEC, idea_pkg::ST_INV_WR: begin
                if ((r_state == idea_pkg::ST_DEC) && i_status.need_inv) begin
                    o_cmd.op = idea_pkg::DP_INV_LOAD;
                    n_iter   = '0;
                end else begin
                    o_cmd.op = (r_state == idea_pkg::ST_DEC) ? idea_pkg::DP_DEC_WR
                                                             : idea_pkg::DP_INV_WR;
                    if (w_last_key) begin
                        n_row        = '0;
                        n_slot       = '0;
                        n_phase      = '0;
                        n_keys_ready = 1'b1;
                    end else if (w_row_end) begin
                        n_row  = r_row + 1'b1;
                        n_slot = '0;
                    end else begin
                        n_slot = r_slot + 3'd1;
                    end
                end
            end
            idea_pkg::ST_INV: begin
                o_cmd.op = idea_pkg::DP_INV_STEP;
                n_iter   = r_iter + 4'd1;
            end
            idea_pkg::ST_ROUND: begin
                case (r_phase)
                    2'd0:    o_cmd.op = idea_pkg::DP_PH0;
                    2'd1:    o_cmd.op = idea_pkg::DP_PH1;
                    default: o_cmd.op = idea_pkg::DP_PH2;
                endcase
                if (r_phase == 2'd2) begin
                    n_phase = '0;
                    n_row   = r_row + 1'b1;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            idea_pkg::ST_XFORM: begin
                if (w_out_free) begin
                    o_cmd.op    = idea_pkg::DP_XFORM;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= idea_pkg::ST_IDLE;
            r_row        <= '0;
            r_slot       <= '0;
            r_word       <= '0;
            r_phase      <= '0;
            r_iter       <= '0;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_slot       <= n_slot;
            r_word       <= n_word;
            r_phase      <= n_phase;
            r_iter       <= n_iter;
            r_keys_ready <= n_keys_ready;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/idea_block_cipher_top.sv =====
// An accepted block runs all rounds and the output transform before its result is offered.
// After a key write the first block also waits for subkey expansion: the encryption set is
// written first, then the decryption set, each multiplicative subkey above 1 being inverted first.
// Only one block is in flight: a new block is accepted only once the last result is registered.
// Each round takes three passes of the shared multipliers, one per dependent multiplication. Reset
// is synchronous and active low; it clears the key and mode registers and marks the subkeys stale.
module idea_block_cipher_top #(
    parameter int ROUNDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idea_in_if.sink     i_in,
    idea_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        r_decrypt;
    logic        w_wr;
    logic [1:0]  w_idx;
    logic        w_key_wr;

    idea_pkg::t_dp_cmd    w_cmd;
    idea_pkg::t_dp_status w_status;

    // Configuration registers, one 64-bit slot each
    assign pready   = 1'b1;
    assign w_idx    = paddr[4:3];
    assign w_wr     = psel && penable && pwrite;
    assign w_key_wr = w_wr && ((w_idx == idea_pkg::REG_KEY_HIGH) ||
                               (w_idx == idea_pkg::REG_KEY_LOW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_decrypt  <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                idea_pkg::REG_KEY_HIGH: r_key_high <= pwdata;
                idea_pkg::REG_KEY_LOW:  r_key_low  <= pwdata;
                idea_pkg::REG_DECRYPT:  r_decrypt  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (w_idx)
            idea_pkg::REG_KEY_HIGH: prdata = r_key_high;
            idea_pkg::REG_KEY_LOW:  prdata = r_key_low;
            idea_pkg::REG_DECRYPT:  prdata = {63'd0, r_decrypt};
            default:                prdata = '0;
        endcase
    end

    idea_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_wr    (w_key_wr),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    idea_datapath #(.ROUNDS(ROUNDS)) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_data_block   (i_in.data_block),
        .i_key_high     (r_key_high),
        .i_key_low      (r_key_low),
        .i_decrypt      (r_decrypt),
        .o_status       (w_status),
        .o_result_block (o_out.result_block)
    );

endmodule

// ===== rtl/core/idea_chk.sv =====
module idea_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_result_block
);

    // A waiting result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn before it was taken");

    // A waiting result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_result_block))
        else $error("result payload changed while stalled");

    // Only one block is in flight: the input closes once a beat is taken
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still open after a block was accepted");

    // No result can appear in the cycle after a block is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too soon after an accepted block");

endmodule

bind idea_block_cipher_top idea_chk u_idea_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_block (o_out.result_block)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int NUM_ROUNDS = 8;
    localparam int NUM_SUBKEYS = 6 * NUM_ROUNDS + 4;
    localparam int RAND_PHASES = 10;
    localparam int BLOCKS_PER_PHASE = 125;
    // Register index with nothing behind it
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [63:0] mode_word;
        logic [63:0] plain;
        logic [63:0] cipher;
        bit          typed;
    } t_vector;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    idea_in_if  blk_in ();
    idea_out_if blk_out ();

    idea_block_cipher_top #(.ROUNDS(NUM_ROUNDS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (blk_in),
        .o_out   (blk_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the key registers and both subkey schedules.
    logic [63:0] key_hi_q;
    logic [63:0] key_lo_q;
    logic        decrypt_q;
    logic [15:0] enc_sk [NUM_SUBKEYS];
    logic [15:0] dec_sk [NUM_SUBKEYS];

    logic [63:0] expected_blocks [$];
    logic [63:0] typed_cipher;
    bit          typed_valid;
    int          errors;
    int          idle_pct;
    int          stall_pct;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog for a hung run.
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    // Multiplication modulo 2^16+1, where zero stands for 2^16.
    function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        logic [15:0] lo;
        logic [15:0] hi;
        p  = {16'd0, a} * {16'd0, b};
        lo = p[15:0];
        hi = p[31:16];
        if (p != 32'd0) begin
            return lo - hi + {15'd0, lo < hi};
        end else if (a == 16'd0) begin
            return 16'd1 - b;
        end
        return 16'd1 - a;
    endfunction

    // Inverse modulo the prime 2^16+1, by raising to the power 2^16-1.
    function automatic logic [15:0] inv_mod(input logic [15:0] a);
        logic [15:0] r;
        logic [15:0] base;
        r = 16'd1;
        base = a;
        if (a <= 16'd1) begin
            return a;
        end
        for (int i = 0; i < 16; i++) begin
            r = mul_mod(r, base);
            base = mul_mod(base, base);
        end
        return r;
    endfunction

    // Rebuild both subkey schedules from the shadow key.
    task automatic expand_schedule();
        logic [127:0] k;
        int e;
        k = {key_hi_q, key_lo_q};
        for (int i = 0; i < NUM_SUBKEYS; i++) begin
            enc_sk[i] = k[127 - 16 * (i % 8) -: 16];
            if (i % 8 == 7) begin
                k = {k[102:0], k[127:103]};
            end
        end
        dec_sk[0] = inv_mod(enc_sk[6 * NUM_ROUNDS]);
        dec_sk[1] = -enc_sk[6 * NUM_ROUNDS + 1];
        dec_sk[2] = -enc_sk[6 * NUM_ROUNDS + 2];
        dec_sk[3] = inv_mod(enc_sk[6 * NUM_ROUNDS + 3]);
        for (int r = 1; r < NUM_ROUNDS; r++) begin
            e = 6 * (NUM_ROUNDS - r);
            dec_sk[6 * r - 2] = enc_sk[e + 4];
            dec_sk[6 * r - 1] = enc_sk[e + 5];
            dec_sk[6 * r]     = inv_mod(enc_sk[e]);
            dec_sk[6 * r + 1] = -enc_sk[e + 2];
            dec_sk[6 * r + 2] = -enc_sk[e + 1];
            dec_sk[6 * r + 3] = inv_mod(enc_sk[e + 3]);
        end
        dec_sk[6 * NUM_ROUNDS - 2] = enc_sk[4];
        dec_sk[6 * NUM_ROUNDS - 1] = enc_sk[5];
        dec_sk[6 * NUM_ROUNDS]     = inv_mod(enc_sk[0]);
        dec_sk[6 * NUM_ROUNDS + 1] = -enc_sk[1];
        dec_sk[6 * NUM_ROUNDS + 2] = -enc_sk[2];
        dec_sk[6 * NUM_ROUNDS + 3] = inv_mod(enc_sk[3]);
    endtask

    // Full IDEA transform of one block under the current schedule and direction.
    function automatic logic [63:0] idea_transform(input logic [63:0] blk);
        logic [15:0] k [NUM_SUBKEYS];
        logic [15:0] x1, x2, x3, x4, t1, t2;
        for (int i = 0; i < NUM_SUBKEYS; i++) begin
            k[i] = decrypt_q ? dec_sk[i] : enc_sk[i];
        end
        {x1, x2, x3, x4} = blk;
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            x1 = mul_mod(x1, k[6 * r]);
            x2 = x2 + k[6 * r + 1];
            x3 = x3 + k[6 * r + 2];
            x4 = mul_mod(x4, k[6 * r + 3]);
            t2 = mul_mod(x1 ^ x3, k[6 * r + 4]);
            t1 = mul_mod((x2 ^ x4) + t2, k[6 * r + 5]);
            t2 = t1 + t2;
            x1 = x1 ^ t1;
            x4 = x4 ^ t2;
            t2 = t2 ^ x2;
            x2 = x3 ^ t1;
            x3 = t2;
        end
        return {mul_mod(x1, k[6 * NUM_ROUNDS]), x3 + k[6 * NUM_ROUNDS + 1],
                x2 + k[6 * NUM_ROUNDS + 2], mul_mod(x4, k[6 * NUM_ROUNDS + 3])};
    endfunction

    // One APB write; the shadow registers follow the block's decode.
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            idea_pkg::REG_KEY_HIGH: key_hi_q = value;
            idea_pkg::REG_KEY_LOW:  key_lo_q = value;
            idea_pkg::REG_DECRYPT:  decrypt_q = value[0];
            default: ;
        endcase
        expand_schedule();
    endtask

    // Wait until every outstanding block has come back.
    task automatic drain();
        while (expected_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one beat, idling beforehand at the current rate, and hold until taken.
    task automatic send_block(input logic [63:0] blk);
        while ($urandom_range(99) < idle_pct) begin
            blk_in.valid = 1'b0;
            @(negedge i_clk);
        end
        blk_in.valid      = 1'b1;
        blk_in.data_block = blk;
        do begin
            @(posedge i_clk);
        end while (!blk_in.ready);
        @(negedge i_clk);
        blk_in.valid = 1'b0;
    endtask

    // Random block with the corner words 0, 1 and 0xFFFF well represented.
    function automatic logic [63:0] random_block();
        logic [63:0] b;
        for (int w = 0; w < 4; w++) begin
            case ($urandom_range(7))
                0:       b[16 * w +: 16] = 16'h0000;
                1:       b[16 * w +: 16] = 16'hFFFF;
                2:       b[16 * w +: 16] = 16'h0001;
                default: b[16 * w +: 16] = 16'($urandom);
            endcase
        end
        return b;
    endfunction

    // Predict each accepted input beat; a typed value takes precedence.
    always @(posedge i_clk) begin
        if (i_rst_n && blk_in.valid && blk_in.ready) begin
            expected_blocks.push_back(typed_valid ? typed_cipher
                                                  : idea_transform(blk_in.data_block));
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && blk_out.valid && blk_out.ready) begin
            if (expected_blocks.size() == 0) begin
                $error("result_block: none expected, actual %h", blk_out.result_block);
                errors++;
            end else begin
                logic [63:0] want;
                want = expected_blocks.pop_front();
                if (want !== blk_out.result_block) begin
                    $error("result_block: expected %h, actual %h", want,
                           blk_out.result_block);
                    errors++;
                end
            end
        end
    end

    // Result-side back-pressure.
    always @(negedge i_clk) begin
        blk_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        t_vector vectors [$];
        logic [63:0] cur_hi;
        logic [63:0] cur_lo;
        logic [63:0] cur_mode;
        logic [63:0] hi;
        logic [63:0] lo;

        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        blk_in.valid = 1'b0;
        blk_in.data_block = '0;
        blk_out.ready = 1'b0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        typed_valid = 1'b0;
        typed_cipher = '0;
        key_hi_q = '0;
        key_lo_q = '0;
        decrypt_q = 1'b0;
        expand_schedule();

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: reset key first, then the published vector both ways, then further keys.
        vectors = '{
            '{64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_0000, 64'h0, 1'b0},
            '{64'h0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
            '{64'h0, 64'h0, 64'h0, 64'h0001_0000_FFFF_0001, 64'h0, 1'b0},
            '{64'h0, 64'h0, 64'h1, 64'h0000_0000_0000_0000, 64'h0, 1'b0},
            '{64'h0, 64'h0, 64'h1, 64'h8000_7FFF_0001_FFFE, 64'h0, 1'b0},
            '{64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 64'h0,
              64'h0000_0001_0002_0003, 64'h11FB_ED2B_0198_6DE5, 1'b1},
            '{64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 64'h1,
              64'h11FB_ED2B_0198_6DE5, 64'h0000_0001_0002_0003, 1'b1},
            // Only the low bit of a wide direction write counts.
            '{64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 64'hFFFF_FFFF_FFFF_FFFE,
              64'h0000_0001_0002_0003, 64'h11FB_ED2B_0198_6DE5, 1'b1},
            '{64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 64'h8000_0000_0000_0001,
              64'hFFFF_0000_FFFF_0000, 64'h0, 1'b0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
              64'h0000_0000_0000_0000, 64'h0, 1'b0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1,
              64'h0123_4567_89AB_CDEF, 64'h0, 1'b0},
            '{64'h5555_AAAA_5555_AAAA, 64'h0000_0001_0000_FFFF, 64'h1,
              64'hAAAA_5555_0000_FFFF, 64'h0, 1'b0},
            '{64'h5555_AAAA_5555_AAAA, 64'h0000_0001_0000_FFFF, 64'h0,
              64'h0001_0001_0001_0001, 64'h0, 1'b0}
        };

        cur_hi = '0;
        cur_lo = '0;
        cur_mode = '0;
        foreach (vectors[i]) begin
            if (vectors[i].key_hi != cur_hi || vectors[i].key_lo != cur_lo
                    || vectors[i].mode_word != cur_mode) begin
                drain();
                if (vectors[i].key_hi != cur_hi) begin
                    reg_write(idea_pkg::REG_KEY_HIGH, vectors[i].key_hi);
                end
                if (vectors[i].key_lo != cur_lo) begin
                    reg_write(idea_pkg::REG_KEY_LOW, vectors[i].key_lo);
                end
                if (vectors[i].mode_word != cur_mode) begin
                    reg_write(idea_pkg::REG_DECRYPT, vectors[i].mode_word);
                end
                cur_hi = vectors[i].key_hi;
                cur_lo = vectors[i].key_lo;
                cur_mode = vectors[i].mode_word;
            end
            typed_valid  = vectors[i].typed;
            typed_cipher = vectors[i].cipher;
            send_block(vectors[i].plain);
        end
        blk_in.valid = 1'b0;
        drain();
        typed_valid = 1'b0;

        // An address beyond the register map must leave everything untouched.
        reg_write(REG_UNMAPPED, 64'hDEAD_BEEF_0BAD_F00D);

        // Random phases, each with a new key and direction and one of four idle and stall patterns.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       begin hi = '1; lo = '1; end
                1:       begin hi = '0; lo = '0; end
                default: begin hi = {$urandom, $urandom}; lo = {$urandom, $urandom}; end
            endcase
            reg_write(idea_pkg::REG_KEY_HIGH, hi);
            reg_write(idea_pkg::REG_KEY_LOW, lo);
            reg_write(idea_pkg::REG_DECRYPT, {$urandom, $urandom});
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                send_block(random_block());
            end
            blk_in.valid = 1'b0;
            drain();
            idle_pct = 0;
            stall_pct = 0;
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
